FILE: design/u8u16_pkg.sv
// UTF-8 to UTF-16 transcoder: shared types and code point constants.
// No dependencies; imported by u8u16_decode and utf8_to_utf16_decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

	// code point boundaries, 21-bit scalar space
	localparam logic [20:0] CP_SURR_FIRST = 21'h00D800;
	localparam logic [20:0] CP_SURR_END   = 21'h00E000;
	localparam logic [20:0] CP_SUPP_FIRST = 21'h010000;
	localparam logic [20:0] CP_LIMIT      = 21'h110000;

	// UTF-16 surrogate bases
	localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

	localparam logic [1:0]  UNITS_NONE    = 2'd0;
	localparam logic [1:0]  UNITS_ONE     = 2'd1;
	localparam logic [1:0]  UNITS_PAIR    = 2'd2;

	typedef struct packed {
		logic full;
		logic broken;
		logic illegal;
	} flags_t;

	typedef struct packed {
		logic [1:0]  unit_count;
		logic [15:0] first_unit;
		logic [15:0] second_unit;
		flags_t      flags;
		logic        string_done;
	} result_t;

endpackage

`default_nettype wire

FILE: design/u8u16_decode.sv
// Per-string decode state and the single-pass byte decode logic.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_en,     // byte in s1 moves on this cycle
	input  wire logic [7:0]          byte_value,
	input  wire logic                end_of_string,
	input  wire logic [15:0]         usable_units,
	output u8u16_pkg::result_t       result
);
	import u8u16_pkg::*;

	logic [1:0]  pend_q, pend_d, pend_dec;
	logic [20:0] acc_q, acc_d, acc_ext, supp_off;
	logic [15:0] uw_q;
	logic [16:0] uw_plus1;
	flags_t      flags_q, flags_d;
	logic        stop_q, stop_d;
	logic [1:0]  n;
	logic [15:0] u1, u2;
	logic        done;

	assign acc_ext  = {acc_q[14:0], byte_value[5:0]};
	assign pend_dec = pend_q - 2'd1;
	assign supp_off = acc_ext - CP_SUPP_FIRST;
	assign uw_plus1 = {1'b0, uw_q} + 17'd1;
	assign done     = end_of_string || (byte_value == 8'h00);

	always_comb begin
		n       = UNITS_NONE;
		u1      = 16'h0000;
		u2      = 16'h0000;
		pend_d  = pend_q;
		acc_d   = acc_q;
		flags_d = flags_q;
		stop_d  = stop_q;
		if (byte_value == 8'h00) begin
			// terminator byte: nothing out
		end else if (stop_q || (uw_q >= usable_units)) begin
			flags_d.full = 1'b1;
			stop_d       = 1'b1;
		end else if (pend_q == 2'd0) begin
			case (byte_value) inside
				[8'h01:8'h7F]: begin
					n  = UNITS_ONE;
					u1 = {8'h00, byte_value};
				end
				[8'hC0:8'hDF]: begin
					pend_d = 2'd1;
					acc_d  = {16'h0000, byte_value[4:0]};
				end
				[8'hE0:8'hEF]: begin
					pend_d = 2'd2;
					acc_d  = {17'h00000, byte_value[3:0]};
				end
				[8'hF0:8'hF7]: begin
					pend_d = 2'd3;
					acc_d  = {18'h00000, byte_value[2:0]};
				end
				default: begin
					flags_d.illegal = 1'b1;
				end
			endcase
		end else if (byte_value[7:6] == 2'b10) begin
			acc_d  = acc_ext;
			pend_d = pend_dec;
			if (pend_dec == 2'd0) begin
				acc_d = 21'h000000;
				if (((acc_ext != 21'h000000) && (acc_ext < CP_SURR_FIRST)) ||
				    ((acc_ext >= CP_SURR_END) && (acc_ext < CP_SUPP_FIRST))) begin
					n  = UNITS_ONE;
					u1 = acc_ext[15:0];
				end else if ((acc_ext >= CP_SUPP_FIRST) && (acc_ext < CP_LIMIT)) begin
					if (uw_plus1 >= {1'b0, usable_units}) begin
						// pair does not fit: stop output for this string
						flags_d.full = 1'b1;
						stop_d       = 1'b1;
					end else begin
						n  = UNITS_PAIR;
						u1 = HI_SURR_BASE + {6'b000000, supp_off[19:10]};
						u2 = LO_SURR_BASE + {6'b000000, supp_off[9:0]};
					end
				end
			end
		end else begin
			// cut sequence: drop the byte, abandon the partial value
			acc_d          = 21'h000000;
			pend_d         = 2'd0;
			flags_d.broken = 1'b1;
		end
	end

	assign result.unit_count  = n;
	assign result.first_unit  = u1;
	assign result.second_unit = u2;
	assign result.flags       = flags_d;
	assign result.string_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			acc_q   <= 21'h000000;
			uw_q    <= 16'h0000;
			flags_q <= '0;
			stop_q  <= 1'b0;
		end else if (step_en) begin
			if (done) begin
				pend_q  <= 2'd0;
				acc_q   <= 21'h000000;
				uw_q    <= 16'h0000;
				flags_q <= '0;
				stop_q  <= 1'b0;
			end else begin
				pend_q  <= pend_d;
				acc_q   <= acc_d;
				uw_q    <= uw_q + {14'h0000, n};
				flags_q <= flags_d;
				stop_q  <= stop_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done |=> (pend_q == 2'd0) && (uw_q == 16'h0000) && (flags_q == '0))
		else $error("string state not cleared after last byte");
	a_acc_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd0) |-> (acc_q == 21'h000000))
		else $error("accumulator holds bits with no sequence open");
	a_stop_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> flags_q.full)
		else $error("output stopped without full flag");
`endif

endmodule

`default_nettype wire

FILE: design/utf8_to_utf16_decoder.sv
// Path: an accepted byte is held in s1, decoded combinationally, and its result is registered
// in s2, which drives m_axis; a stall on m_axis holds both stages.
// Throughput: one byte per cycle while m_axis is not stalled; the decode is one pass of mask/compare logic.
// The result register frees s1, so a new byte is taken while a result waits.
// Reset (arst_n low, async): stages empty, string state clear, capacity 65535.
// Top level: byte stream in, UTF-16 units plus sticky flags out.
// Depends on u8u16_pkg and u8u16_decode.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input bytes
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  wire logic        s_axis_tlast,   // end_of_string
	// output units
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [1:0] unit_count, [17:2] first_unit,
	                                         // [33:18] second_unit, [39:34] zero
	output logic [2:0]       m_axis_tuser,   // [0] illegal_lead, [1] broken_sequence,
	                                         // [2] buffer_full
	output logic             m_axis_tlast,   // string_done
	// capacity register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data        // capacity_units
);
	import u8u16_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_comb;
	logic [15:0] cap_q;
	logic [15:0] usable;
	logic        advance;

	// capacity includes a terminator slot; zero means no room at all
	assign cfg_ready = 1'b1;
	assign usable    = (cap_q != 16'h0000) ? (cap_q - 16'd1) : 16'h0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// s1 moves into the result register when that register is empty or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	// decode core: string state updates only when the byte in s1 moves on
	u8u16_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.byte_value    (byte_s1),
		.end_of_string (eos_s1),
		.usable_units  (usable),
		.result        (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b000000, res_s2.second_unit, res_s2.first_unit,
	                        res_s2.unit_count};
	assign m_axis_tuser  = {res_s2.flags.full, res_s2.flags.broken, res_s2.flags.illegal};
	assign m_axis_tlast  = res_s2.string_done;

`ifndef NO_ASSERTIONS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled byte lost from input register");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
		else $error("unit count out of range");
	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != UNITS_PAIR) |-> (m_axis_tdata[33:18] == 16'h0000))
		else $error("second unit set without a pair");
	a_pair_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == UNITS_PAIR) |->
		(m_axis_tdata[17:12] == 6'b110110) && (m_axis_tdata[33:28] == 6'b110111))
		else $error("pair is not a high/low surrogate");
`endif

endmodule

`default_nettype wire
